/* src/sof_pkg.sv */
// Shared constants and codes for the occlusion fade table.
// No dependencies; used by segment_occlusion_fade_table.
package sof_pkg;

  localparam int TABLE_SLOTS_DEF = 64;
  localparam int COORD_BITS_DEF  = 32;

  localparam logic [16:0] OPAQUE     = 17'h10000;
  localparam logic [16:0] DROP_LEVEL = 17'd65471;
  localparam int          SEG_MIN_SQ = 43;

  typedef enum logic [2:0] {
    CMD_CAMERA = 3'd0,
    CMD_FOCUS  = 3'd1,
    CMD_SPHERE = 3'd2,
    CMD_FRAME  = 3'd3,
    CMD_QUERY  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    REG_PROTECT_RADIUS = 3'd0,
    REG_RADIUS_MARGIN  = 3'd1,
    REG_FADE_FLOOR     = 3'd2,
    REG_FADE_OUT_RATE  = 3'd3,
    REG_FADE_IN_RATE   = 3'd4
  } reg_index_t;

endpackage

/* src/segment_occlusion_fade_table.sv */
// Top level of the occlusion fade table: sequencer, shared arithmetic and slot memories.
// Depends on sof_pkg.
//
// Usage: a frame is a camera command, a focus command (with frame time), any number
// of sphere commands and a frame end. Sphere and query commands return one result
// on the output channel; the others return nothing. Commands 5 to 7 are dropped.
// Both channels use valid/stall: a transfer happens when valid is high and stall low.
// The block works on one item at a time and holds in_stall high until it is done.
// Work per item: a query takes an id scan, one slot per cycle, plus an opacity
// read. A sphere takes the scan plus 14 to 16 passes of a shift-add multiplier,
// up to two square roots and up to two restoring divisions. A frame end sweeps
// all slots after one multiply. The single shift-add multiplier, the one-bit-per-cycle
// divider and square root unit do this arithmetic. A finished result sits in the
// output register; if the receiver stalls, the block may accept further items and
// holds its next result until the output register frees. Reset clears points,
// frame time, registers and all valid and seen bits; no clearing pass is needed.
module segment_occlusion_fade_table #(
  parameter int TABLE_SLOTS = sof_pkg::TABLE_SLOTS_DEF,
  parameter int COORD_BITS  = sof_pkg::COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         cmd,
  input  logic [31:0]        entry_id,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic [30:0]        sphere_radius,
  input  logic [15:0]        frame_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [16:0]        opacity,
  output logic               found,
  output logic               table_full,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int MW = COORD_BITS + 1;
  localparam int AW = (2 * MW + 2 > 62) ? 2 * MW + 2 : 62;
  localparam int RW = AW / 2;
  localparam int PW = AW + 2;
  localparam int BW = RW + 1;
  localparam int CW = $clog2(AW + 1);
  localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_SLOTS - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_SRCH, S_OPRD, S_OPWT, S_PROD, S_PACC, S_MUL, S_CHK, S_SQRT, S_LEN,
    S_DIV, S_PROJ, S_D2, S_TGT, S_RDIV, S_RAMP, S_SLEWL, S_SLEW, S_STORE, S_DONE,
    S_FEL, S_FER, S_FEW
  } state_t;

  // configuration
  logic [30:0] protect_radius, radius_margin;
  logic [16:0] fade_floor;
  logic [23:0] fade_out_rate, fade_in_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      protect_radius <= '0;
      radius_margin  <= '0;
      fade_floor     <= '0;
      fade_out_rate  <= '0;
      fade_in_rate   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sof_pkg::REG_PROTECT_RADIUS: protect_radius <= cfg_data;
        sof_pkg::REG_RADIUS_MARGIN:  radius_margin  <= cfg_data;
        sof_pkg::REG_FADE_FLOOR:     fade_floor     <= cfg_data[16:0];
        sof_pkg::REG_FADE_OUT_RATE:  fade_out_rate  <= cfg_data[23:0];
        sof_pkg::REG_FADE_IN_RATE:   fade_in_rate   <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  state_t state, ret;

  logic signed [COORD_BITS-1:0] cam [3];
  logic signed [COORD_BITS-1:0] foc [3];
  logic signed [COORD_BITS-1:0] pnt [3];
  logic [15:0] step_time;
  logic [2:0]  cmd_q;
  logic [31:0] id_in;
  logic [30:0] rad;

  logic [TABLE_SLOTS-1:0] slot_valid, slot_seen;

  // search
  logic [IW:0]   scan;
  logic [IW-1:0] chk_idx, hit_idx, fr_idx, fe_idx;
  logic          chk_ok, hit_f, fr_f;

  // geometry accumulators
  logic [1:0]         axis, psel;
  logic [AW-1:0]      f2, c2, s2;
  logic signed [AW:0] dot;
  logic [16:0]        cur, tgt, newv;

  // shared units
  logic [PW-1:0] m_a, m_acc;
  logic [BW-1:0] m_b;
  logic [AW-1:0] dv_n;
  logic [RW-1:0] dv_d, dv_r;
  logic [AW-1:0] sq_n;
  logic [RW-1:0] sq_root;
  logic [RW:0]   sq_rem;
  logic [CW-1:0] u_cnt;

  // result holding
  logic [16:0] res_op;
  logic        res_found, res_full;

  // memories
  logic [31:0] id_mem   [TABLE_SLOTS];
  logic [16:0] op_mem   [TABLE_SLOTS];
  logic [16:0] pend_mem [TABLE_SLOTS];
  logic [31:0] id_rd;
  logic [16:0] op_rd, pd_rd;
  logic          id_we, op_we, pd_we;
  logic [IW-1:0] id_waddr, op_waddr, pd_waddr, op_raddr;
  logic [16:0]   op_wdata, pd_wdata;

  // divider step
  logic [RW:0] dv_t, dv_sub;
  logic        dv_ge;
  assign dv_t   = {dv_r, dv_n[AW-1]};
  assign dv_ge  = dv_t >= {1'b0, dv_d};
  assign dv_sub = dv_t - {1'b0, dv_d};

  // square root step
  logic [RW+2:0] sq_t, sq_trial, sq_sub;
  logic          sq_ge;
  assign sq_t     = {sq_rem, sq_n[AW-1:AW-2]};
  assign sq_trial = {1'b0, sq_root, 2'b01};
  assign sq_ge    = sq_t >= sq_trial;
  assign sq_sub   = sq_t - sq_trial;

  // per-axis differences and magnitudes
  logic signed [MW-1:0] tf, tc, sg;
  logic [MW-1:0] tf_m, tc_m, sg_m, pa, pb;
  always_comb begin
    tf   = MW'(pnt[axis]) - MW'(foc[axis]);
    tc   = MW'(pnt[axis]) - MW'(cam[axis]);
    sg   = MW'(foc[axis]) - MW'(cam[axis]);
    tf_m = tf[MW-1] ? MW'(-tf) : MW'(tf);
    tc_m = tc[MW-1] ? MW'(-tc) : MW'(tc);
    sg_m = sg[MW-1] ? MW'(-sg) : MW'(sg);
    unique case (psel)
      2'd0:    begin pa = tf_m; pb = tf_m; end
      2'd1:    begin pa = tc_m; pb = tc_m; end
      2'd2:    begin pa = sg_m; pb = sg_m; end
      default: begin pa = tc_m; pb = sg_m; end
    endcase
  end

  // target and slew helpers
  logic [16:0]   flo;
  logic [RW+1:0] d_w, rad_w, lim_w;
  logic          opq_chk;
  logic [AW-1:0] d2;
  logic [24:0]   st25, up_sum, fe_sum;
  logic [16:0]   dn_v, slew_v, fe_v;
  always_comb begin
    flo     = (fade_floor > sof_pkg::OPAQUE) ? sof_pkg::OPAQUE : fade_floor;
    d_w     = (RW+2)'(sq_root);
    rad_w   = (RW+2)'(rad);
    lim_w   = (RW+2)'(rad) + (RW+2)'(radius_margin);
    opq_chk = (PW'(f2) < m_acc) || (s2 < AW'(sof_pkg::SEG_MIN_SQ)) ||
              (dot <= 0) || (dot[AW-1:0] >= s2);
    d2      = (PW'(c2) > m_acc) ? AW'(PW'(c2) - m_acc) : '0;
    st25    = {1'b0, m_acc[39:16]};
    up_sum  = 25'(cur) + st25;
    dn_v    = (st25 >= 25'(cur)) ? 17'd0 : cur - st25[16:0];
    if (tgt < cur) begin
      slew_v = (dn_v < tgt) ? tgt : dn_v;
    end else if (tgt > cur) begin
      slew_v = (up_sum > 25'(tgt)) ? tgt : up_sum[16:0];
    end else begin
      slew_v = cur;
    end
    fe_sum = 25'(op_rd) + st25;
    fe_v   = (fe_sum > 25'(sof_pkg::OPAQUE)) ? sof_pkg::OPAQUE : fe_sum[16:0];
  end

  // memory write and read control
  always_comb begin
    id_we    = 1'b0;
    op_we    = 1'b0;
    pd_we    = 1'b0;
    id_waddr = fr_idx;
    pd_waddr = hit_f ? hit_idx : fr_idx;
    pd_wdata = newv;
    op_waddr = fe_idx;
    op_wdata = fe_v;
    op_raddr = (state == S_OPRD) ? hit_idx : fe_idx;
    if (state == S_STORE) begin
      pd_we = hit_f || fr_f;
      if (!hit_f && fr_f) begin
        id_we    = 1'b1;
        op_we    = 1'b1;
        op_waddr = fr_idx;
        op_wdata = sof_pkg::OPAQUE;
      end
    end else if (state == S_FEW && slot_valid[fe_idx]) begin
      if (slot_seen[fe_idx]) begin
        op_we    = 1'b1;
        op_wdata = pd_rd;
      end else begin
        op_we = fe_sum < 25'(sof_pkg::DROP_LEVEL);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (id_we) id_mem[id_waddr] <= id_in;
    id_rd <= id_mem[scan[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (op_we) op_mem[op_waddr] <= op_wdata;
    op_rd <= op_mem[op_raddr];
  end

  always_ff @(posedge clk) begin
    if (pd_we) pend_mem[pd_waddr] <= pd_wdata;
    pd_rd <= pend_mem[fe_idx];
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret        <= S_IDLE;
      out_valid  <= 1'b0;
      slot_valid <= '0;
      slot_seen  <= '0;
      step_time  <= '0;
      for (int i = 0; i < 3; i++) begin
        cam[i] <= '0;
        foc[i] <= '0;
      end
    end else begin
      // drop the offered result once it transfers, unless a new one takes its place
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q  <= cmd;
            id_in  <= entry_id;
            rad    <= sphere_radius;
            pnt[0] <= COORD_BITS'(pos_x);
            pnt[1] <= COORD_BITS'(pos_y);
            pnt[2] <= COORD_BITS'(pos_z);
            scan   <= '0;
            chk_ok <= 1'b0;
            hit_f  <= 1'b0;
            fr_f   <= 1'b0;
            unique case (cmd)
              sof_pkg::CMD_CAMERA: begin
                cam[0] <= COORD_BITS'(pos_x);
                cam[1] <= COORD_BITS'(pos_y);
                cam[2] <= COORD_BITS'(pos_z);
              end
              sof_pkg::CMD_FOCUS: begin
                foc[0]    <= COORD_BITS'(pos_x);
                foc[1]    <= COORD_BITS'(pos_y);
                foc[2]    <= COORD_BITS'(pos_z);
                step_time <= frame_time;
              end
              sof_pkg::CMD_SPHERE, sof_pkg::CMD_QUERY: state <= S_SRCH;
              sof_pkg::CMD_FRAME: state <= S_FEL;
              default: ;
            endcase
          end
        end
        S_SRCH: begin
          // issue one id read per cycle, check the slot read last cycle
          if (scan < (IW+1)'(TABLE_SLOTS)) begin
            chk_idx <= scan[IW-1:0];
            chk_ok  <= 1'b1;
            scan    <= scan + 1'b1;
          end else begin
            chk_ok <= 1'b0;
          end
          if (chk_ok) begin
            if (slot_valid[chk_idx] && id_rd == id_in) begin
              if (!hit_f) begin
                hit_f   <= 1'b1;
                hit_idx <= chk_idx;
              end
            end else if (!slot_valid[chk_idx] && !fr_f) begin
              fr_f   <= 1'b1;
              fr_idx <= chk_idx;
            end
            if (chk_idx == LAST_SLOT) state <= S_OPRD;
          end
        end
        S_OPRD: state <= S_OPWT;
        S_OPWT: begin
          cur  <= hit_f ? op_rd : sof_pkg::OPAQUE;
          f2   <= '0;
          c2   <= '0;
          s2   <= '0;
          dot  <= '0;
          axis <= '0;
          psel <= '0;
          if (cmd_q == sof_pkg::CMD_QUERY) begin
            res_op    <= hit_f ? op_rd : sof_pkg::OPAQUE;
            res_found <= hit_f;
            res_full  <= 1'b0;
            state     <= S_DONE;
          end else begin
            state <= S_PROD;
          end
        end
        S_PROD: begin
          m_a   <= PW'(pa);
          m_b   <= BW'(pb);
          m_acc <= '0;
          u_cnt <= CW'(BW);
          ret   <= S_PACC;
          state <= S_MUL;
        end
        S_PACC: begin
          unique case (psel)
            2'd0: f2 <= f2 + m_acc[AW-1:0];
            2'd1: c2 <= c2 + m_acc[AW-1:0];
            2'd2: s2 <= s2 + m_acc[AW-1:0];
            default: begin
              if (tc[MW-1] != sg[MW-1]) dot <= dot - $signed({1'b0, m_acc[AW-1:0]});
              else dot <= dot + $signed({1'b0, m_acc[AW-1:0]});
            end
          endcase
          if (psel == 2'd3) begin
            psel <= '0;
            if (axis == 2'd2) begin
              m_a   <= PW'(protect_radius);
              m_b   <= BW'(protect_radius);
              m_acc <= '0;
              u_cnt <= CW'(BW);
              ret   <= S_CHK;
              state <= S_MUL;
            end else begin
              axis  <= axis + 1'b1;
              state <= S_PROD;
            end
          end else begin
            psel  <= psel + 1'b1;
            state <= S_PROD;
          end
        end
        S_MUL: begin
          // shift-add: one multiplier bit per cycle
          if (m_b[0]) m_acc <= m_acc + m_a;
          m_a   <= m_a << 1;
          m_b   <= m_b >> 1;
          u_cnt <= u_cnt - 1'b1;
          if (u_cnt == CW'(1)) state <= ret;
        end
        S_CHK: begin
          if (opq_chk) begin
            tgt   <= sof_pkg::OPAQUE;
            state <= S_SLEWL;
          end else begin
            sq_n    <= s2;
            sq_root <= '0;
            sq_rem  <= '0;
            u_cnt   <= CW'(RW);
            ret     <= S_LEN;
            state   <= S_SQRT;
          end
        end
        S_SQRT: begin
          // two radicand bits per cycle, one root bit out
          sq_n <= sq_n << 2;
          if (sq_ge) begin
            sq_rem  <= sq_sub[RW:0];
            sq_root <= {sq_root[RW-2:0], 1'b1};
          end else begin
            sq_rem  <= sq_t[RW:0];
            sq_root <= {sq_root[RW-2:0], 1'b0};
          end
          u_cnt <= u_cnt - 1'b1;
          if (u_cnt == CW'(1)) state <= ret;
        end
        S_LEN: begin
          dv_n  <= dot[AW-1:0];
          dv_d  <= sq_root;
          dv_r  <= '0;
          u_cnt <= CW'(AW);
          ret   <= S_PROJ;
          state <= S_DIV;
        end
        S_DIV: begin
          // restoring division, quotient bits shift in behind the dividend
          dv_r  <= dv_ge ? dv_sub[RW-1:0] : dv_t[RW-1:0];
          dv_n  <= {dv_n[AW-2:0], dv_ge};
          u_cnt <= u_cnt - 1'b1;
          if (u_cnt == CW'(1)) state <= ret;
        end
        S_PROJ: begin
          m_a   <= PW'(dv_n[RW:0]);
          m_b   <= dv_n[RW:0];
          m_acc <= '0;
          u_cnt <= CW'(BW);
          ret   <= S_D2;
          state <= S_MUL;
        end
        S_D2: begin
          sq_n    <= d2;
          sq_root <= '0;
          sq_rem  <= '0;
          u_cnt   <= CW'(RW);
          ret     <= S_TGT;
          state   <= S_SQRT;
        end
        S_TGT: begin
          if (d_w <= rad_w) begin
            tgt   <= flo;
            state <= S_SLEWL;
          end else if (d_w >= lim_w) begin
            tgt   <= sof_pkg::OPAQUE;
            state <= S_SLEWL;
          end else begin
            m_a   <= PW'(sof_pkg::OPAQUE - flo);
            m_b   <= BW'(d_w - rad_w);
            m_acc <= '0;
            u_cnt <= CW'(BW);
            ret   <= S_RDIV;
            state <= S_MUL;
          end
        end
        S_RDIV: begin
          dv_n  <= AW'(m_acc);
          dv_d  <= RW'(radius_margin);
          dv_r  <= '0;
          u_cnt <= CW'(AW);
          ret   <= S_RAMP;
          state <= S_DIV;
        end
        S_RAMP: begin
          tgt   <= flo + dv_n[16:0];
          state <= S_SLEWL;
        end
        S_SLEWL: begin
          m_a   <= (tgt < cur) ? PW'(fade_out_rate) : PW'(fade_in_rate);
          m_b   <= BW'(step_time);
          m_acc <= '0;
          u_cnt <= CW'(BW);
          ret   <= S_SLEW;
          state <= S_MUL;
        end
        S_SLEW: begin
          newv  <= slew_v;
          state <= S_STORE;
        end
        S_STORE: begin
          if (hit_f) begin
            slot_seen[hit_idx] <= 1'b1;
          end else if (fr_f) begin
            slot_valid[fr_idx] <= 1'b1;
            slot_seen[fr_idx]  <= 1'b1;
          end
          res_op    <= newv;
          res_found <= hit_f || fr_f;
          res_full  <= !(hit_f || fr_f);
          state     <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            opacity    <= res_op;
            found      <= res_found;
            table_full <= res_full;
            state      <= S_IDLE;
          end
        end
        S_FEL: begin
          fe_idx <= '0;
          m_a    <= PW'(fade_in_rate);
          m_b    <= BW'(step_time);
          m_acc  <= '0;
          u_cnt  <= CW'(BW);
          ret    <= S_FER;
          state  <= S_MUL;
        end
        S_FER: state <= S_FEW;
        S_FEW: begin
          if (slot_valid[fe_idx]) begin
            if (slot_seen[fe_idx]) begin
              slot_seen[fe_idx] <= 1'b0;
            end else if (fe_sum >= 25'(sof_pkg::DROP_LEVEL)) begin
              slot_valid[fe_idx] <= 1'b0;
            end
          end
          if (fe_idx == LAST_SLOT) begin
            state <= S_IDLE;
          end else begin
            fe_idx <= fe_idx + 1'b1;
            state  <= S_FER;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_seen_valid: assert property (@(posedge clk) disable iff (rst)
    (slot_seen & ~slot_valid) == '0)
    else $error("seen slot is not valid");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> opacity <= sof_pkg::OPAQUE)
    else $error("opacity above opaque");

  a_out_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(found && table_full))
    else $error("found and table_full both set");

  a_srch_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_SRCH |=> (state == S_SRCH || state == S_OPRD))
    else $error("id scan left to a wrong state");
`endif

endmodule

/* dv/tb_top.sv */
// Self-checking bench for segment_occlusion_fade_table: directed and random frames.
// Depends on sof_pkg and the block; predicts each result and compares it on transfer.
module tb_top;

  // Spare command codes that the block must drop without a result.
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam int UNIT = 65536;  // 1.0 in Q16.16
  localparam int SETTLE = 400;  // covers a frame-end sweep of all slots

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] id;
    logic [31:0] x, y, z;
    logic [30:0] rad;
    logic [15:0] ft;
  } item_t;

  typedef struct packed {
    logic [16:0] opacity;
    logic        found;
    logic        full;
  } fade_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [16:0] opacity;
  logic found, table_full;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = sof_pkg::REG_PROTECT_RADIUS;
  logic [30:0] cfg_data = '0;
  item_t cur = '0;

  segment_occlusion_fade_table DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cur.cmd), .entry_id(cur.id),
    .pos_x(cur.x), .pos_y(cur.y), .pos_z(cur.z),
    .sphere_radius(cur.rad), .frame_time(cur.ft),
    .out_valid(out_valid), .out_stall(out_stall),
    .opacity(opacity), .found(found), .table_full(table_full),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: points, frame time, slot table and register copies.
  // ---------------------------------------------------------------------------
  longint      cam_pt[3], foc_pt[3];
  logic [15:0] dt_q;
  bit          sv_valid[64], sv_seen[64];
  logic [31:0] sv_id[64];
  logic [16:0] sv_opac[64], sv_pend[64];
  logic [63:0] m_protect, m_margin, m_floor, m_out_rate, m_in_rate;

  item_t     cmd_q[$];
  fade_res_t fade_expect_q[$];
  int        errors = 0;
  int        n_items = 0;
  bit        idle_on = 1'b1;

  function automatic logic [63:0] isqrt(logic [127:0] n);
    logic [63:0]  r, c;
    logic [127:0] cc;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      cc = c;
      if (cc * cc <= n) r = c;
    end
    return r;
  endfunction

  // Target opacity for a sphere against the camera-to-focus segment.
  function automatic logic [16:0] occl_target(longint s[3], logic [63:0] rad);
    logic signed [127:0] f2, c2, s2, dot, tf, tc, sg, pr;
    logic [127:0] len, proj, pp, d2;
    logic [63:0]  d, flo;
    f2 = 0; c2 = 0; s2 = 0; dot = 0;
    for (int i = 0; i < 3; i++) begin
      tf = s[i] - foc_pt[i];
      tc = s[i] - cam_pt[i];
      sg = foc_pt[i] - cam_pt[i];
      f2 += tf * tf;
      c2 += tc * tc;
      s2 += sg * sg;
      dot += tc * sg;
    end
    pr = m_protect;
    if (f2 < pr * pr) return sof_pkg::OPAQUE;
    if (s2 < sof_pkg::SEG_MIN_SQ) return sof_pkg::OPAQUE;
    if (dot <= 0 || dot >= s2) return sof_pkg::OPAQUE;
    len = isqrt(s2);
    proj = dot / len;
    pp = proj * proj;
    d2 = (c2 > pp) ? c2 - pp : 0;
    d = isqrt(d2);
    flo = (m_floor > sof_pkg::OPAQUE) ? 64'(sof_pkg::OPAQUE) : m_floor;
    if (d <= rad) return flo[16:0];
    if (d >= rad + m_margin) return sof_pkg::OPAQUE;
    return 17'(flo + ((64'(sof_pkg::OPAQUE) - flo) * (d - rad)) / m_margin);
  endfunction

  function automatic logic [16:0] slew_to(logic [16:0] now, logic [16:0] tgt);
    logic [63:0] st, v;
    if (tgt < now) begin
      st = (m_out_rate * dt_q) >> 16;
      v = (st >= now) ? 64'd0 : now - st;
      return (v < tgt) ? tgt : v[16:0];
    end
    if (tgt > now) begin
      v = now + ((m_in_rate * dt_q) >> 16);
      return (v > tgt) ? tgt : v[16:0];
    end
    return now;
  endfunction

  // Advance the predicted state by one accepted command; queue any result.
  function automatic void fade_predict(item_t it);
    int hit, fr, slot;
    longint p[3];
    logic [16:0] tgt, now, v;
    logic [63:0] nv;
    hit = -1; fr = -1;
    p[0] = longint'($signed(it.x));
    p[1] = longint'($signed(it.y));
    p[2] = longint'($signed(it.z));
    for (int i = 0; i < 64; i++) begin
      if (sv_valid[i] && sv_id[i] == it.id) begin
        if (hit < 0) hit = i;
      end else if (!sv_valid[i] && fr < 0) fr = i;
    end
    case (it.cmd)
      sof_pkg::CMD_CAMERA: cam_pt = p;
      sof_pkg::CMD_FOCUS: begin
        foc_pt = p;
        dt_q = it.ft;
      end
      sof_pkg::CMD_SPHERE: begin
        tgt = occl_target(p, 64'(it.rad));
        now = (hit >= 0) ? sv_opac[hit] : sof_pkg::OPAQUE;
        v = slew_to(now, tgt);
        slot = hit;
        if (slot < 0 && fr >= 0) begin
          slot = fr;
          sv_valid[slot] = 1'b1;
          sv_id[slot] = it.id;
          sv_opac[slot] = sof_pkg::OPAQUE;
        end
        if (slot >= 0) begin
          sv_pend[slot] = v;
          sv_seen[slot] = 1'b1;
        end
        fade_expect_q.push_back('{v, slot >= 0, slot < 0});
      end
      sof_pkg::CMD_FRAME: begin
        for (int i = 0; i < 64; i++) begin
          if (!sv_valid[i]) continue;
          if (sv_seen[i]) begin
            sv_opac[i] = sv_pend[i];
            sv_seen[i] = 1'b0;
          end else begin
            nv = sv_opac[i] + ((m_in_rate * dt_q) >> 16);
            if (nv > sof_pkg::OPAQUE) nv = sof_pkg::OPAQUE;
            if (nv < sof_pkg::DROP_LEVEL) sv_opac[i] = nv[16:0];
            else sv_valid[i] = 1'b0;
          end
        end
      end
      sof_pkg::CMD_QUERY:
        fade_expect_q.push_back('{(hit >= 0) ? sv_opac[hit] : sof_pkg::OPAQUE,
                                  hit >= 0, 1'b0});
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: present at the falling edge, note the transfer at the rising.
  // ---------------------------------------------------------------------------
  bit took = 1'b0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      fade_predict(cur);
      took <= 1'b1;
    end
  end

  always @(negedge clk) begin
    took <= 1'b0;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !took) begin
      // hold the stalled item as it is
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (cmd_q.size() > 0) begin
      cur <= cmd_q.pop_front();
      in_valid <= 1'b1;
      gap_left = idle_on ? $urandom_range(0, 17) : 0;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: compare every transfer with the oldest expectation.
  // ---------------------------------------------------------------------------
  bit got = 1'b0;
  int stall_left = 0;

  always @(posedge clk) begin
    fade_res_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      got <= 1'b1;
      if (fade_expect_q.size() == 0) begin
        $error("result with nothing expected: opacity %0d found %0b table_full %0b",
               opacity, found, table_full);
        errors++;
      end else begin
        exp_r = fade_expect_q.pop_front();
        if (opacity !== exp_r.opacity) begin
          $error("opacity: expected %0d, got %0d", exp_r.opacity, opacity);
          errors++;
        end
        if (found !== exp_r.found) begin
          $error("found: expected %0b, got %0b", exp_r.found, found);
          errors++;
        end
        if (table_full !== exp_r.full) begin
          $error("table_full: expected %0b, got %0b", exp_r.full, table_full);
          errors++;
        end
      end
    end
  end

  // Draw a stall length per result; stall only while a result is offered.
  always @(negedge clk) begin
    got <= 1'b0;
    if (got) stall_left = idle_on ? $urandom_range(0, 17) : 0;
    if (out_valid && stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic set_reg(sof_pkg::reg_index_t idx, logic [30:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      sof_pkg::REG_PROTECT_RADIUS: m_protect = val;
      sof_pkg::REG_RADIUS_MARGIN:  m_margin = val;
      sof_pkg::REG_FADE_FLOOR:     m_floor = val[16:0];
      sof_pkg::REG_FADE_OUT_RATE:  m_out_rate = val[23:0];
      default:                     m_in_rate = val[23:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(logic [30:0] pr, logic [30:0] mg, logic [30:0] fl,
                         logic [30:0] ro, logic [30:0] ri);
    set_reg(sof_pkg::REG_PROTECT_RADIUS, pr);
    set_reg(sof_pkg::REG_RADIUS_MARGIN, mg);
    set_reg(sof_pkg::REG_FADE_FLOOR, fl);
    set_reg(sof_pkg::REG_FADE_OUT_RATE, ro);
    set_reg(sof_pkg::REG_FADE_IN_RATE, ri);
  endtask

  // Drain everything, then let a trailing frame-end sweep finish.
  task automatic wait_idle();
    while (cmd_q.size() > 0 || in_valid || fade_expect_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push(logic [2:0] c, logic [31:0] id, longint x, longint y, longint z,
                      logic [30:0] rad, logic [15:0] ft);
    cmd_q.push_back('{c, id, 32'(x), 32'(y), 32'(z), rad, ft});
    if (c <= sof_pkg::CMD_QUERY) n_items++;
  endtask

  function automatic longint spread(int units);
    return longint'($urandom_range(0, 2 * units * UNIT)) - longint'(units) * UNIT;
  endfunction

  // One well-formed frame: camera, focus, spheres near the segment, queries, and usually an end.
  task automatic push_frame(int n_sph, int id_pool);
    longint c[3], f[3], s[3];
    int t;
    for (int i = 0; i < 3; i++) begin
      c[i] = spread(50);
      f[i] = ($urandom_range(0, 15) == 0) ? c[i] : c[i] + spread(20);
    end
    push(sof_pkg::CMD_CAMERA, $urandom, c[0], c[1], c[2], $urandom, $urandom);
    push(sof_pkg::CMD_FOCUS, $urandom, f[0], f[1], f[2], $urandom, $urandom);
    for (int k = 0; k < n_sph; k++) begin
      t = $urandom_range(0, 300);
      for (int i = 0; i < 3; i++) s[i] = c[i] + ((f[i] - c[i]) * t) / 256 + spread(3);
      push(sof_pkg::CMD_SPHERE, $urandom_range(0, id_pool), s[0], s[1], s[2],
           $urandom_range(0, 3 * UNIT), $urandom);
      if ($urandom_range(0, 5) == 0)
        push(sof_pkg::CMD_QUERY, $urandom_range(0, id_pool + 4), $urandom, $urandom,
             $urandom, $urandom, $urandom);
    end
    if ($urandom_range(0, 9) != 0)
      push(sof_pkg::CMD_FRAME, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Raw noise: any command code, every field at full range.
  task automatic push_noise();
    logic [2:0] c;
    c = $urandom_range(sof_pkg::CMD_CAMERA, CMD_SPARE_HI);
    push(c, $urandom, $signed($urandom), $signed($urandom), $signed($urandom),
         $urandom, $urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    longint big, neg;
    int goal;
    big = 64'sh7FFF_FFFF;
    neg = -64'sh8000_0000;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: a ten-unit segment on the x axis, one-unit floor of a quarter.
    set_all(UNIT, 2 * UNIT, 16384, 24'h20_0000, 24'h08_0000);
    push(sof_pkg::CMD_QUERY, 7, 0, 0, 0, 0, 0);                         // unknown id
    push(sof_pkg::CMD_CAMERA, 0, 0, 0, 0, 0, 0);
    push(sof_pkg::CMD_FOCUS, 0, 10 * UNIT, 0, 0, 0, 16'hFFFF);
    push(sof_pkg::CMD_SPHERE, 7, 5 * UNIT, 0, 0, UNIT, 0);              // fully blocking
    push(sof_pkg::CMD_SPHERE, 8, 5 * UNIT, 2 * UNIT, 0, UNIT, 0);       // on the ramp
    push(sof_pkg::CMD_SPHERE, 9, 5 * UNIT, 9 * UNIT, 0, UNIT, 0);       // clear of segment
    push(sof_pkg::CMD_SPHERE, 10, -UNIT, 0, 0, UNIT, 0);                // behind the camera
    push(sof_pkg::CMD_SPHERE, 11, 12 * UNIT, 0, 0, UNIT, 0);            // past the focus
    push(sof_pkg::CMD_SPHERE, 12, 10 * UNIT - 100, 0, 0, UNIT, 0);      // protect radius
    push(sof_pkg::CMD_SPHERE, 7, 5 * UNIT, UNIT, 0, 0, 0);              // same id twice
    push(sof_pkg::CMD_QUERY, 7, 0, 0, 0, 0, 0);                         // new slot mid-frame
    push(sof_pkg::CMD_SPHERE, 32'hFFFF_FFFF, big, neg, big, 31'h7FFF_FFFF, 0);
    push(CMD_SPARE_LO, 7, 0, 0, 0, 0, 0);
    push(CMD_SPARE_HI, 7, big, big, big, 31'h7FFF_FFFF, 16'hFFFF);
    push(sof_pkg::CMD_FRAME, 0, 0, 0, 0, 0, 0);
    push(sof_pkg::CMD_QUERY, 7, 0, 0, 0, 0, 0);
    push(sof_pkg::CMD_CAMERA, 0, neg, neg, neg, 0, 0);
    push(sof_pkg::CMD_FOCUS, 0, neg + 3, neg, neg, 0, 16'h0000);         // segment too short
    push(sof_pkg::CMD_SPHERE, 8, neg + 1, neg, neg, 0, 0);
    push(sof_pkg::CMD_FRAME, 0, 0, 0, 0, 0, 0);                         // unseen fade in
    push(sof_pkg::CMD_QUERY, 9, 0, 0, 0, 0, 0);
    wait_idle();

    // Random phases, each under its own register setting.
    goal = n_items + 600;
    for (int ph = 0; n_items < goal; ph++) begin
      idle_on = (ph % 3 != 1);
      case (ph % 6)
        0: set_all(UNIT / 2, 2 * UNIT, 0, 24'hFF_FFFF, 24'h00_4000);
        1: set_all(0, 0, 17'h1FFFF, 24'h00_0000, 24'hFF_FFFF);
        2: set_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, 65536, 24'h01_0000, 0);
        3: set_all($urandom_range(0, 2 * UNIT), $urandom_range(1, 4 * UNIT),
                   $urandom_range(0, 65536), $urandom_range(0, 24'hFF_FFFF),
                   $urandom_range(0, 24'hFF_FFFF));
        4: set_all(UNIT, 31'h7FFF_FFFF, 32768, 24'h40_0000, 24'h10_0000);
        default: set_all($urandom, $urandom, $urandom, $urandom, $urandom);
      endcase
      for (int k = 0; k < 10; k++) begin
        if ($urandom_range(0, 7) == 0) push_noise();
        else push_frame($urandom_range(1, 12), 24);
      end
      if (ph % 4 == 3) push_frame(70, 200);                    // overflow the table
      wait_idle();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(12 * 6000000);
    $display("simulation failed");
    $finish;
  end

endmodule
